FILE: src/spliced_frameshift_protein_align_top_defines.svh
// assertion macros shared by the alignment block
`ifndef SPLICED_FRAMESHIFT_PROTEIN_ALIGN_TOP_DEFINES_SVH
`define SPLICED_FRAMESHIFT_PROTEIN_ALIGN_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with reset disabling
`define SFPA_ASSERT_NOW(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sfpa assertion failed");

// next-cycle implication
`define SFPA_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sfpa assertion failed");

`endif

FILE: src/sfpa_pkg.sv
// shared types and codes for the spliced protein alignment block
package sfpa_pkg;

	localparam logic [1:0] REQ_TABLE = 2'd0;
	localparam logic [1:0] REQ_PROT  = 2'd1;
	localparam logic [1:0] REQ_ROW   = 2'd2;

	localparam logic [2:0] CFG_LENGTH     = 3'd0;
	localparam logic [2:0] CFG_GAP_OPEN   = 3'd1;
	localparam logic [2:0] CFG_GAP_EXTEND = 3'd2;
	localparam logic [2:0] CFG_INTRON     = 3'd3;
	localparam logic [2:0] CFG_FRAMESHIFT = 3'd4;

	localparam int TABLE_DEPTH = 1024;
	localparam int ROW_SAT     = 5;

	typedef struct packed {
		logic accept;
		logic row_init;
		logic calc_a;
		logic calc_b;
		logic row_commit;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic compute;
		logic out_busy;
	} stat_t;

endpackage

FILE: src/spliced_frameshift_protein_align_top.sv
// spliced protein-to-dna alignment score with frameshifts, top level
// table and residue load items are taken in the idle state and end there; the first two
// row items of a sequence go through the row and commit states only, every later row item
// runs the four-step column sweep over the row memories for each of its L protein columns
// the last row item adds an emit step (held while the previous result waits) and a
// row clearing pass over all MAX_PROTEIN entries; after reset the same clearing pass runs first
module spliced_frameshift_protein_align_top #(
	parameter int MAX_PROTEIN = 1024,
	parameter int ALPHABET_SIZE = 32,
	parameter int SCORE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [9:0]         table_index,
	input  logic signed [7:0]  entry_value,
	input  logic [4:0]         row_residue,
	input  logic [6:0]         donor_next,
	input  logic [6:0]         acceptor_here,
	input  logic               last_row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] final_score,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [10:0]        cfg_data
);

	localparam int PW = $clog2(MAX_PROTEIN);

	sfpa_pkg::cmd_t cmd;
	sfpa_pkg::stat_t stat;
	logic [PW-1:0] addr;
	logic [PW-1:0] lm1;

	sfpa_ctrl #(.MAX_PROTEIN(MAX_PROTEIN)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.last_row (last_row),
		.lm1      (lm1),
		.stat     (stat),
		.cmd      (cmd),
		.addr     (addr)
	);

	sfpa_datapath #(
		.MAX_PROTEIN   (MAX_PROTEIN),
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.SCORE_BITS    (SCORE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.addr          (addr),
		.lm1           (lm1),
		.req_type      (req_type),
		.table_index   (table_index),
		.entry_value   (entry_value),
		.row_residue   (row_residue),
		.donor_next    (donor_next),
		.acceptor_here (acceptor_here),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.final_score   (final_score),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

endmodule

FILE: src/sfpa_ctrl.sv
// sequencer for loads, column sweeps, result hand-off and row clearing
`include "spliced_frameshift_protein_align_top_defines.svh"

module sfpa_ctrl #(
	parameter int MAX_PROTEIN = 1024,
	localparam int PW = $clog2(MAX_PROTEIN)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      req_type,
	input  logic            last_row,
	input  logic [PW-1:0]   lm1,
	input  sfpa_pkg::stat_t stat,
	output sfpa_pkg::cmd_t  cmd,
	output logic [PW-1:0]   addr
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROW, ST_RD, ST_TBL, ST_CA, ST_CB, ST_COMMIT, ST_EMIT, ST_CLEAR
	} state_t;

	state_t state_q;
	logic [PW-1:0] addr_q;
	logic last_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign addr = addr_q;

	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		cmd.row_init = (state_q == ST_ROW) && stat.compute;
		cmd.calc_a = (state_q == ST_CA);
		cmd.calc_b = (state_q == ST_CB);
		cmd.row_commit = (state_q == ST_COMMIT);
		cmd.emit = (state_q == ST_EMIT) && !stat.out_busy;
		cmd.clear = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == sfpa_pkg::REQ_ROW) begin
						last_q <= last_row;
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					addr_q <= '0;
					state_q <= stat.compute ? ST_RD : ST_COMMIT;
				end
				ST_RD:  state_q <= ST_TBL;
				ST_TBL: state_q <= ST_CA;
				ST_CA:  state_q <= ST_CB;
				ST_CB: begin
					if (addr_q == lm1) begin
						state_q <= ST_COMMIT;
					end else begin
						addr_q <= addr_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_COMMIT: state_q <= last_q ? ST_EMIT : ST_IDLE;
				ST_EMIT: begin
					if (!stat.out_busy) begin
						addr_q <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (addr_q == PW'(MAX_PROTEIN - 1)) begin
						addr_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SFPA_ASSERT_NOW(a_col_in_range, (state_q == ST_RD || state_q == ST_CB), (addr_q <= lm1))
	`SFPA_ASSERT_NEXT(a_clear_done, (state_q == ST_CLEAR && addr_q == PW'(MAX_PROTEIN - 1)),
		(state_q == ST_IDLE))
	`SFPA_ASSERT_NOW(a_one_cmd, 1'b1,
		$onehot0({cmd.row_init, cmd.calc_a, cmd.calc_b, cmd.row_commit, cmd.emit, cmd.clear}))

endmodule

FILE: src/sfpa_datapath.sv
// row memories, tables, recurrence arithmetic and result register
`include "spliced_frameshift_protein_align_top_defines.svh"

module sfpa_datapath #(
	parameter int MAX_PROTEIN = 1024,
	parameter int ALPHABET_SIZE = 32,
	parameter int SCORE_BITS = 16,
	localparam int PW = $clog2(MAX_PROTEIN)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfpa_pkg::cmd_t     cmd,
	output sfpa_pkg::stat_t    stat,
	input  logic [PW-1:0]      addr,
	output logic [PW-1:0]      lm1,
	input  logic [1:0]         req_type,
	input  logic [9:0]         table_index,
	input  logic signed [7:0]  entry_value,
	input  logic [4:0]         row_residue,
	input  logic [6:0]         donor_next,
	input  logic [6:0]         acceptor_here,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] final_score,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [10:0]        cfg_data
);

	localparam int SB = SCORE_BITS;
	localparam int W = SB + 2;
	localparam logic signed [SB-1:0] NEG = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [SB-1:0] POS = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [W-1:0] NEG_W = {3'b111, {(SB-1){1'b0}}};
	localparam logic signed [W-1:0] POS_W = {3'b000, {(SB-1){1'b1}}};

	function automatic logic signed [SB-1:0] clip(input logic signed [W-1:0] x);
		if (x < NEG_W) return NEG;
		if (x > POS_W) return POS;
		return x[SB-1:0];
	endfunction

	function automatic logic signed [SB-1:0] sub_p(input logic signed [SB-1:0] a,
			input logic [7:0] p);
		return clip($signed({{2{a[SB-1]}}, a}) - $signed({{(W-8){1'b0}}, p}));
	endfunction

	function automatic logic signed [SB-1:0] add_s(input logic signed [SB-1:0] a,
			input logic signed [7:0] s);
		return clip($signed({{2{a[SB-1]}}, a}) + $signed({{(W-8){s[7]}}, s}));
	endfunction

	function automatic logic signed [SB-1:0] mx(input logic signed [SB-1:0] a,
			input logic signed [SB-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [4:0] clamp_code(input logic [4:0] c);
		return (int'(c) >= ALPHABET_SIZE) ? 5'(ALPHABET_SIZE - 1) : c;
	endfunction

	// config registers
	logic [10:0] len_q;
	logic [7:0] q_q, e_q, r_q, f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 11'd1;
			q_q <= '0;
			e_q <= '0;
			r_q <= '0;
			f_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfpa_pkg::CFG_LENGTH:     len_q <= cfg_data;
				sfpa_pkg::CFG_GAP_OPEN:   q_q <= cfg_data[7:0];
				sfpa_pkg::CFG_GAP_EXTEND: e_q <= cfg_data[7:0];
				sfpa_pkg::CFG_INTRON:     r_q <= cfg_data[7:0];
				sfpa_pkg::CFG_FRAMESHIFT: f_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) lm1 = '0;
		else if (int'(len_q) > MAX_PROTEIN) lm1 = PW'(MAX_PROTEIN - 1);
		else lm1 = PW'(int'(len_q) - 1);
	end

	// row sequence state
	logic [2:0] rc_q;
	logic [1:0] slot_q;
	logic [6:0] hd0_q, hd1_q, ha2_q, ha3_q;
	logic [4:0] res_q;
	logic [6:0] dn_q, ac_q;
	logic signed [SB-1:0] last_h_q, ins_q;
	logic out_valid_q;
	logic signed [15:0] final_q;

	logic [1:0] s0, s1, s2, s3;
	assign s0 = slot_q;
	assign s1 = slot_q + 2'd3;
	assign s2 = slot_q + 2'd2;
	assign s3 = slot_q + 2'd1;

	assign stat.compute = (rc_q >= 3'd2);
	assign stat.out_busy = out_valid_q;
	assign out_valid = out_valid_q;
	assign final_score = final_q;

	// H at column -1 for row rc - k
	function automatic logic signed [SB-1:0] bnd(input logic [2:0] rc, input int k,
			input logic [7:0] f);
		int rr;
		rr = int'(rc) - k;
		if (rr == -1) return '0;
		if (rr == 0 || rr == 1) return sub_p('0, f);
		return NEG;
	endfunction

	// memories
	logic [4:0] prot_mem [MAX_PROTEIN];
	logic [7:0] tbl_mem [sfpa_pkg::TABLE_DEPTH];
	logic signed [SB-1:0] h_mem [4][MAX_PROTEIN];
	logic signed [SB-1:0] d_mem [4][MAX_PROTEIN];
	logic signed [SB-1:0] abc_mem [3][MAX_PROTEIN];

	logic [4:0] prot_q;
	logic signed [7:0] tbl_q;
	logic signed [SB-1:0] rd_h_q [4];
	logic signed [SB-1:0] rd_d_q [4];
	logic signed [SB-1:0] rd_abc_q [3];
	logic [9:0] tbl_raddr;

	assign tbl_raddr = 10'(int'(clamp_code(res_q)) * ALPHABET_SIZE) +
		10'(clamp_code(prot_q));

	always_ff @(posedge clk) begin
		if (cmd.accept && req_type == sfpa_pkg::REQ_TABLE)
			tbl_mem[table_index] <= entry_value;
		if (cmd.accept && req_type == sfpa_pkg::REQ_PROT && int'(table_index) < MAX_PROTEIN)
			prot_mem[PW'(table_index)] <= entry_value[4:0];
		prot_q <= prot_mem[addr];
		tbl_q <= $signed(tbl_mem[tbl_raddr]);
	end

	// recurrence stage a
	logic signed [SB-1:0] hp1_q, hp2_q, hp3_q;
	logic signed [SB-1:0] m_s1, d_s1, a_s1, b_s1, c_s1;
	logic signed [SB-1:0] h1j, h2j, h3j, d3j;
	logic signed [SB-1:0] t_h, t_d, t_a, t_b, t_c, t_u, t_m;

	assign h1j = rd_h_q[s1];
	assign h2j = rd_h_q[s2];
	assign h3j = rd_h_q[s3];
	assign d3j = rd_d_q[s3];

	always_comb begin
		t_h = add_s(hp3_q, tbl_q);
		t_d = sub_p(mx(sub_p(h3j, q_q), d3j), e_q);
		t_a = mx(sub_p(sub_p(h1j, r_q), {1'b0, hd1_q}), rd_abc_q[0]);
		t_u = sub_p(hp1_q, r_q);
		t_b = mx(sub_p(t_u, {1'b0, hd0_q}), rd_abc_q[1]);
		t_c = mx(sub_p(t_u, {1'b0, dn_q}), rd_abc_q[2]);
		t_m = mx(mx(mx(t_h, t_d), mx(sub_p(t_a, {1'b0, ac_q}), sub_p(t_b, {1'b0, ha3_q}))),
			mx(mx(sub_p(t_c, {1'b0, ha2_q}), sub_p(h1j, f_q)),
			mx(mx(sub_p(h2j, f_q), sub_p(hp1_q, f_q)), sub_p(hp2_q, f_q))));
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_a) begin
			m_s1 <= t_m;
			d_s1 <= t_d;
			a_s1 <= t_a;
			b_s1 <= t_b;
			c_s1 <= t_c;
		end
		if (cmd.row_init) begin
			hp3_q <= bnd(rc_q, 3, f_q);
			hp2_q <= bnd(rc_q, 2, f_q);
			hp1_q <= bnd(rc_q, 1, f_q);
		end else if (cmd.calc_b) begin
			hp3_q <= h3j;
			hp2_q <= h2j;
			hp1_q <= h1j;
		end
		if (cmd.accept) begin
			res_q <= row_residue;
			dn_q <= donor_next;
			ac_q <= acceptor_here;
		end
	end

	// stage b: insertion chain along the row
	logic signed [SB-1:0] ins_n, h_n;
	assign ins_n = sub_p(mx(sub_p(last_h_q, q_q), ins_q), e_q);
	assign h_n = mx(m_s1, ins_n);

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (cmd.clear || (cmd.calc_b && s0 == 2'(k))) begin
				h_mem[k][addr] <= cmd.clear ? NEG : h_n;
				d_mem[k][addr] <= cmd.clear ? NEG : d_s1;
			end
			rd_h_q[k] <= h_mem[k][addr];
			rd_d_q[k] <= d_mem[k][addr];
		end
		if (cmd.clear || cmd.calc_b) begin
			abc_mem[0][addr] <= cmd.clear ? NEG : a_s1;
			abc_mem[1][addr] <= cmd.clear ? NEG : b_s1;
			abc_mem[2][addr] <= cmd.clear ? NEG : c_s1;
		end
		for (int k = 0; k < 3; k++) rd_abc_q[k] <= abc_mem[k][addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) final_q <= last_h_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			slot_q <= '0;
			hd0_q <= '0;
			hd1_q <= '0;
			ha2_q <= '0;
			ha3_q <= '0;
			last_h_q <= NEG;
			ins_q <= NEG;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.row_init) begin
				last_h_q <= NEG;
				ins_q <= NEG;
			end else if (cmd.calc_b) begin
				last_h_q <= h_n;
				ins_q <= ins_n;
			end
			if (cmd.row_commit) begin
				ha3_q <= ha2_q;
				ha2_q <= ac_q;
				hd1_q <= hd0_q;
				hd0_q <= dn_q;
				if (int'(rc_q) < sfpa_pkg::ROW_SAT) rc_q <= rc_q + 3'd1;
				if (stat.compute) slot_q <= slot_q + 2'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				rc_q <= '0;
				slot_q <= '0;
				hd0_q <= '0;
				hd1_q <= '0;
				ha2_q <= '0;
				ha3_q <= '0;
				last_h_q <= NEG;
			end
		end
	end

	`SFPA_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_q)
	`SFPA_ASSERT_NEXT(a_emit_restart, cmd.emit, (rc_q == 3'd0 && slot_q == 2'd0 && out_valid_q))
	`SFPA_ASSERT_NOW(a_rc_sat, 1'b1, (int'(rc_q) <= sfpa_pkg::ROW_SAT))

endmodule

FILE: tb/tb_top.sv
// testbench for the spliced protein alignment block: scoreboard class with a row-recurrence predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXP = 1024;
	localparam longint NEG = -32768;
	localparam longint POS = 32767;
	// slowest row sweeps all MAXP columns, then a clearing pass runs over MAXP entries
	localparam int SETTLE = 5 * MAXP + 40;
	localparam int IDLE_LIMIT = 40000;
	// protein positions in use and residue codes stored there stay small
	localparam int PRELOAD_LEN = 64;
	localparam int PROT_CODES = 4;

	typedef struct {
		logic [1:0] req;
		logic [9:0] idx;
		logic signed [7:0] val;
		logic [4:0] res;
		logic [6:0] dn;
		logic [6:0] ac;
		logic last;
	} req_item_t;

	class align_scoreboard;
		logic [4:0] protein[MAXP];
		logic [7:0] scores[sfpa_pkg::TABLE_DEPTH];
		longint h_row[4][MAXP];
		longint d_row[4][MAXP];
		longint abc_row[3][MAXP];
		int unsigned rows_seen, slot_next;
		longint splice[4]; // d(i), d(i-1), a(i-1), a(i-2)
		int unsigned plen;
		longint q, e, r, f;
		logic signed [15:0] expected_scores[$];

		function new();
			foreach (protein[j]) protein[j] = '0;
			foreach (scores[j]) scores[j] = '0;
			plen = 1;
			q = 0;
			e = 0;
			r = 0;
			f = 0;
			clear_rows();
		endfunction

		function void clear_rows();
			for (int k = 0; k < 4; k++)
				for (int j = 0; j < MAXP; j++) begin
					h_row[k][j] = NEG;
					d_row[k][j] = NEG;
					if (k < 3) abc_row[k][j] = NEG;
				end
			rows_seen = 0;
			slot_next = 0;
			for (int k = 0; k < 4; k++) splice[k] = 0;
		endfunction

		function longint sat(longint x);
			if (x < NEG) return NEG;
			if (x > POS) return POS;
			return x;
		endfunction

		function longint mx(longint a, longint b);
			return a > b ? a : b;
		endfunction

		function longint edge_h(int rr);
			if (rr == -1) return 0;
			if (rr == 0 || rr == 1) return -f;
			return NEG;
		endfunction

		function int unsigned eff_len();
			if (plen < 1) return 1;
			if (plen > MAXP) return MAXP;
			return plen;
		endfunction

		function void set_reg(logic [2:0] idx, logic [10:0] data);
			case (idx)
				sfpa_pkg::CFG_LENGTH: plen = data;
				sfpa_pkg::CFG_GAP_OPEN: q = data[7:0];
				sfpa_pkg::CFG_GAP_EXTEND: e = data[7:0];
				sfpa_pkg::CFG_INTRON: r = data[7:0];
				sfpa_pkg::CFG_FRAMESHIFT: f = data[7:0];
				default: ;
			endcase
		endfunction

		function void sweep_row(int i, logic [4:0] res, longint dip1, longint ai);
			int unsigned len, s0, s1, s2, s3;
			longint ins, last_h, h, t, u, h1p, h2p, h3p, s;
			logic [9:0] addr;
			len = eff_len();
			s0 = slot_next & 3;
			s1 = (slot_next + 3) & 3;
			s2 = (slot_next + 2) & 3;
			s3 = (slot_next + 1) & 3;
			ins = NEG;
			last_h = NEG;
			for (int j = 0; j < len; j++) begin
				h3p = j ? h_row[s3][j-1] : edge_h(i - 3);
				h2p = j ? h_row[s2][j-1] : edge_h(i - 2);
				h1p = j ? h_row[s1][j-1] : edge_h(i - 1);
				addr = {res, protein[j]};
				s = longint'($signed(scores[addr]));
				h = sat(h3p + s);
				t = mx(sat(last_h - q), ins);
				ins = sat(t - e);
				h = mx(h, ins);
				t = sat(mx(sat(h_row[s3][j] - q), d_row[s3][j]) - e);
				d_row[s0][j] = t;
				h = mx(h, t);
				t = mx(sat(sat(h_row[s1][j] - r) - splice[1]), abc_row[0][j]);
				abc_row[0][j] = t;
				h = mx(h, sat(t - ai));
				u = sat(h1p - r);
				t = mx(sat(u - splice[0]), abc_row[1][j]);
				abc_row[1][j] = t;
				h = mx(h, sat(t - splice[3]));
				t = mx(sat(u - dip1), abc_row[2][j]);
				abc_row[2][j] = t;
				h = mx(h, sat(t - splice[2]));
				h = mx(h, sat(h_row[s1][j] - f));
				h = mx(h, sat(h_row[s2][j] - f));
				h = mx(h, sat(h1p - f));
				h = mx(h, sat(h2p - f));
				h_row[s0][j] = h;
				last_h = h;
			end
			slot_next = (slot_next + 1) & 3;
		endfunction

		// an accepted input item updates the prediction
		function void note_item(req_item_t it);
			longint hv;
			case (it.req)
				sfpa_pkg::REQ_TABLE: scores[it.idx] = it.val;
				sfpa_pkg::REQ_PROT: protein[it.idx] = it.val[4:0];
				sfpa_pkg::REQ_ROW: begin
					if (rows_seen >= 2) sweep_row(rows_seen, it.res, it.dn, it.ac);
					splice[3] = splice[2];
					splice[2] = it.ac;
					splice[1] = splice[0];
					splice[0] = it.dn;
					if (rows_seen < sfpa_pkg::ROW_SAT) rows_seen++;
					if (it.last) begin
						hv = h_row[(slot_next + 3) & 3][eff_len() - 1];
						expected_scores.push_back(hv[15:0]);
						clear_rows();
					end
				end
				default: ;
			endcase
		endfunction

		function bit check_score(logic signed [15:0] got, output string msg);
			logic signed [15:0] want;
			if (expected_scores.size() == 0) begin
				msg = $sformatf("unexpected final_score %0d", got);
				return 0;
			end
			want = expected_scores.pop_front();
			msg = $sformatf("final_score got %0d want %0d", got, want);
			return got === want;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [9:0] table_index = '0;
	logic signed [7:0] entry_value = '0;
	logic [4:0] row_residue = '0;
	logic [6:0] donor_next = '0;
	logic [6:0] acceptor_here = '0;
	logic last_row = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] final_score;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [10:0] cfg_data = '0;

	align_scoreboard sb;
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 0;
	int stall_left = 0;

	spliced_frameshift_protein_align_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .table_index(table_index), .entry_value(entry_value),
		.row_residue(row_residue), .donor_next(donor_next),
		.acceptor_here(acceptor_here), .last_row(last_row),
		.out_valid(out_valid), .out_ready(out_ready), .final_score(final_score),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		string msg;
		if (in_valid && in_ready)
			sb.note_item('{req_type, table_index, entry_value, row_residue,
				donor_next, acceptor_here, last_row});
		if (out_valid && out_ready)
			if (!sb.check_score(final_score, msg)) report_mismatch(msg);
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: stall_left <= $urandom_range(0, 3);
				4: stall_left <= $urandom_range(10, 60);
				default: stall_left <= 0;
			endcase
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		if (calm) return 0;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: return $urandom_range(1, 3);
			5: return $urandom_range(15, 50);
			default: return 0;
		endcase
	endfunction

	// called at a clock edge, returns at the edge where the item was taken
	task automatic send_item(req_item_t it, int gap);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req_type <= it.req;
		table_index <= it.idx;
		entry_value <= it.val;
		row_residue <= it.res;
		donor_next <= it.dn;
		acceptor_here <= it.ac;
		last_row <= it.last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic req_item_t mk(logic [1:0] req, logic [9:0] idx, logic signed [7:0] val,
			logic [4:0] res, logic [6:0] dn, logic [6:0] ac, logic last);
		req_item_t it;
		it.req = req;
		it.idx = idx;
		it.val = val;
		it.res = res;
		it.dn = dn;
		it.ac = ac;
		it.last = last;
		return it;
	endfunction

	function automatic req_item_t rand_item(logic [1:0] req, logic last);
		return mk(req, 10'($urandom), 8'($urandom), 5'($urandom), 7'($urandom),
			7'($urandom), last);
	endfunction

	// residue code below PROT_CODES, with random upper bits that the block drops
	function automatic logic signed [7:0] prot_val();
		return {3'($urandom), 3'b000, 2'($urandom_range(0, PROT_CODES - 1))};
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_scores.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [10:0] len, logic [7:0] gq, logic [7:0] ge,
			logic [7:0] ri, logic [7:0] fs);
		logic [10:0] vals[5];
		logic [2:0] idxs[5];
		vals = '{len, {3'b0, gq}, {3'b0, ge}, {3'b0, ri}, {3'b0, fs}};
		idxs = '{sfpa_pkg::CFG_LENGTH, sfpa_pkg::CFG_GAP_OPEN, sfpa_pkg::CFG_GAP_EXTEND,
			sfpa_pkg::CFG_INTRON, sfpa_pkg::CFG_FRAMESHIFT};
		in_valid <= 1'b0;
		for (int k = 0; k < 5; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			sb.set_reg(idxs[k], vals[k]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// well-formed sequences with random content, plus loads and noise
	task automatic random_phase(int n_items, int max_seq);
		int sent, len, pick;
		sent = 0;
		while (sent < n_items) begin
			calm = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_item(rand_item(sfpa_pkg::REQ_TABLE, 1'($urandom)), pick_gap());
				sent++;
			end else if (pick < 14) begin
				send_item(mk(sfpa_pkg::REQ_PROT, 10'($urandom), prot_val(), 5'($urandom),
					7'($urandom), 7'($urandom), 1'($urandom)), pick_gap());
				sent++;
			end else if (pick < 17) begin
				send_item(rand_item(2'd3, 1'($urandom)), pick_gap());
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
					: $urandom_range(3, max_seq);
				for (int k = 0; k < len; k++)
					send_item(rand_item(sfpa_pkg::REQ_ROW, k == len - 1), pick_gap());
				sent += len;
			end
		end
		calm = 0;
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// preload the protein positions in use and every table entry they can reach
		calm = 1;
		for (int k = 0; k < PRELOAD_LEN; k++)
			send_item(mk(sfpa_pkg::REQ_PROT, 10'(k), prot_val(), 0, 0, 0, 1'($urandom)), 0);
		for (int rs = 0; rs < 32; rs++)
			for (int c = 0; c < PROT_CODES; c++)
				send_item(mk(sfpa_pkg::REQ_TABLE, 10'(rs * 32 + c), 8'($urandom),
					0, 0, 0, 1'($urandom)), 0);
		calm = 0;

		write_regs(3, 0, 0, 0, 0);
		send_item(mk(sfpa_pkg::REQ_TABLE, 0, -128, 0, 0, 0, 0), 0);
		send_item(mk(sfpa_pkg::REQ_TABLE, 1023, 127, 0, 0, 0, 0), 1);
		send_item(mk(sfpa_pkg::REQ_PROT, 0, 8'sh63, 0, 0, 0, 1), 0);
		send_item(mk(sfpa_pkg::REQ_PROT, 1023, 0, 0, 0, 0, 0), 0);
		send_item(mk(2'd3, 10'h3ff, -1, 5'h1f, 7'h7f, 7'h7f, 1), 0);
		// sequence ending on its first row, then on its second
		send_item(mk(sfpa_pkg::REQ_ROW, 0, 0, 31, 127, 127, 1), 0);
		send_item(mk(sfpa_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0), 2);
		send_item(mk(sfpa_pkg::REQ_ROW, 0, 0, 31, 127, 0, 1), 0);
		for (int k = 0; k < 7; k++)
			send_item(mk(sfpa_pkg::REQ_ROW, 0, 0, (k & 1) ? 5'd31 : 5'd0,
				(k & 2) ? 7'd127 : 7'd0, (k & 4) ? 7'd127 : 7'd0, k == 6), 0);
		for (int k = 0; k < 6; k++)
			send_item(mk(sfpa_pkg::REQ_ROW, 0, 0, 0, 127, 127, k == 5), 0);
		settle();

		write_regs(1, 255, 255, 255, 255);
		random_phase(110, 10);
		settle();
		write_regs(0, 7, 1, 30, 5);
		random_phase(100, 12);
		settle();
		for (int p = 0; p < 4; p++) begin
			write_regs(11'($urandom_range(1, 24)), 8'($urandom), 8'($urandom_range(0, 20)),
				8'($urandom), 8'($urandom_range(0, 40)));
			random_phase(80, 14);
			settle();
		end

		while (sb.expected_scores.size() != 0) begin
			report_mismatch("final_score never arrived");
			void'(sb.expected_scores.pop_front());
		end
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

FILE: spliced_frameshift_protein_align_top.f
+incdir+src
src/sfpa_pkg.sv
src/sfpa_ctrl.sv
src/sfpa_datapath.sv
src/spliced_frameshift_protein_align_top.sv
tb/tb_top.sv
